// ===== rtl/gba_pkg.sv =====
// shared types, codes and constants of the grouped bitmap id allocator
`timescale 1ns / 1ps
package gba_pkg;

    localparam int MAX_GROUPS_DEF = 16;
    localparam int MAX_IPG_DEF    = 256;

    localparam int ID_W      = 13;
    localparam int CNT_W     = 9;
    localparam int NG_W      = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX   = 9'd511;
    localparam logic [ID_W-1:0]  FREE_MAX  = 13'd8191;
    localparam logic [CNT_W-1:0] IPG_RST   = 9'd256;
    localparam logic [NG_W-1:0]  NG_RST    = 5'd16;
    localparam logic [ID_W-1:0]  TOTAL_RST = 13'd4096;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_FORMAT = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IPG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd2;

    typedef struct packed {
        logic [1:0]      action;
        logic [ID_W-1:0] id_in;
        logic            is_directory;
    } gba_in_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] id_out;
        logic [ID_W-1:0] free_total;
    } gba_out_t;

    typedef struct packed {
        logic take_in;
        logic alloc_init;
        logic grp_next;
        logic grp_open;
        logic word_check;
        logic word_next;
        logic alloc_commit;
        logic div_start;
        logic free_locate;
        logic free_commit;
        logic fmt_init;
        logic fmt_step;
        logic res_nofree;
        logic res_range;
        logic load_out;
    } gba_cmd_t;

    typedef struct packed {
        logic grp_exhausted;
        logic grp_skip;
        logic word_hit;
        logic word_last;
        logic div_busy;
        logic id_zero;
        logic free_bad;
        logic fmt_last;
    } gba_sts_t;

endpackage

// ===== rtl/grouped_bitmap_id_allocator_top.sv =====
// top level of the grouped bitmap id allocator
//
// channel   signals                                   payload
// in        in_valid / in_ready / in_data             gba_in_t action, id_in, is_directory
// out       out_valid / out_ready / out_data          gba_out_t status, id_out, free_total
// cfg       cfg_valid / cfg_ready / cfg_index         cfg_data register value
//
// one word at a time; a finished result waits in the output register while the next word runs
// allocate: visits groups from the last one used, scanning bitmap words for a free bit
// free: a 13-step restoring division by the group size, then the bit is cleared in its word
// format: resets every group counter; bitmap words carry valid bits cleared by reset and format
// reset is asynchronous active low and needs no clearing pass
`timescale 1ns / 1ps
module grouped_bitmap_id_allocator_top #(
    parameter int MAX_GROUPS        = gba_pkg::MAX_GROUPS_DEF,
    parameter int MAX_IDS_PER_GROUP = gba_pkg::MAX_IPG_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gba_pkg::gba_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gba_pkg::gba_out_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gba_pkg::ID_W-1:0]      cfg_data
);
    import gba_pkg::*;

    gba_cmd_t cmd;
    gba_sts_t sts;

    assign cfg_ready = 1'b1;

    gba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    gba_dp #(
        .MAX_GROUPS        (MAX_GROUPS),
        .MAX_IDS_PER_GROUP (MAX_IDS_PER_GROUP)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/gba_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gba_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gba_pkg::ID_W-1:0]  dividend,
    input  logic [gba_pkg::CNT_W-1:0] divisor,
    output logic                      busy,
    output logic [gba_pkg::ID_W-1:0]  quotient,
    output logic [gba_pkg::CNT_W-1:0] remainder
);
    import gba_pkg::*;

    localparam int CW = $clog2(ID_W + 1);

    logic [CNT_W:0]   rem_reg, rem_next;
    logic [ID_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CNT_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg[CNT_W-1:0], quo_reg[ID_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CW'(ID_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? (trial - {1'b0, dvs_reg}) : trial;
            quo_next = {quo_reg[ID_W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[CNT_W-1:0];

endmodule

// ===== rtl/gba_ctrl.sv =====
// sequencing state machine of the allocator
`timescale 1ns / 1ps
module gba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_action,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gba_pkg::gba_cmd_t cmd,
    input  gba_pkg::gba_sts_t sts
);
    import gba_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_ALLOC_INIT = 4'd1;
    localparam logic [3:0] S_GRP_CHK    = 4'd2;
    localparam logic [3:0] S_RD         = 4'd3;
    localparam logic [3:0] S_CHK        = 4'd4;
    localparam logic [3:0] S_ALLOC_UPD  = 4'd5;
    localparam logic [3:0] S_FREE_START = 4'd6;
    localparam logic [3:0] S_DIV        = 4'd7;
    localparam logic [3:0] S_FREE_CHK   = 4'd8;
    localparam logic [3:0] S_FREE_RD    = 4'd9;
    localparam logic [3:0] S_FREE_WR    = 4'd10;
    localparam logic [3:0] S_FMT_INIT   = 4'd11;
    localparam logic [3:0] S_FMT        = 4'd12;
    localparam logic [3:0] S_DONE       = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    unique case (in_action)
                        ACT_ALLOC:  state_next = S_ALLOC_INIT;
                        ACT_FREE:   state_next = S_FREE_START;
                        ACT_FORMAT: state_next = S_FMT_INIT;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_ALLOC_INIT:
            begin
                cmd.alloc_init = 1'b1;
                state_next     = S_GRP_CHK;
            end
            S_GRP_CHK:
            begin
                if (sts.grp_exhausted)
                begin
                    cmd.res_nofree = 1'b1;
                    state_next     = S_DONE;
                end
                else if (sts.grp_skip)
                begin
                    cmd.grp_next = 1'b1;
                end
                else
                begin
                    cmd.grp_open = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.word_check = 1'b1;
                if (sts.word_hit)
                begin
                    state_next = S_ALLOC_UPD;
                end
                else if (sts.word_last)
                begin
                    cmd.grp_next = 1'b1;
                    state_next   = S_GRP_CHK;
                end
                else
                begin
                    cmd.word_next = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_ALLOC_UPD:
            begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_DONE;
            end
            S_FREE_START:
            begin
                if (sts.id_zero)
                begin
                    cmd.res_range = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                if (sts.free_bad)
                begin
                    cmd.res_range = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.free_locate = 1'b1;
                    state_next      = S_FREE_RD;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                cmd.free_commit = 1'b1;
                state_next      = S_DONE;
            end
            S_FMT_INIT:
            begin
                cmd.fmt_init = 1'b1;
                state_next   = S_FMT;
            end
            S_FMT:
            begin
                cmd.fmt_step = 1'b1;
                if (sts.fmt_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_commit_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> $past(sts.word_hit))
        else $error("allocation committed without a free bit");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while busy");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("loaded result not presented");

    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.alloc_commit, cmd.free_commit, cmd.fmt_step, cmd.grp_next}))
        else $error("conflicting counter updates");

endmodule

// ===== rtl/gba_dp.sv =====
// datapath: configuration, bitmap memory, group counters and result register
`timescale 1ns / 1ps
module gba_dp #(
    parameter int MAX_GROUPS        = gba_pkg::MAX_GROUPS_DEF,
    parameter int MAX_IDS_PER_GROUP = gba_pkg::MAX_IPG_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gba_pkg::gba_cmd_t             cmd,
    output gba_pkg::gba_sts_t             sts,
    input  gba_pkg::gba_in_t              in_data,
    input  logic                          cfg_valid,
    input  logic [gba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gba_pkg::ID_W-1:0]      cfg_data,
    output gba_pkg::gba_out_t             out_data
);
    import gba_pkg::*;

    localparam int GRP_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int NBITS = MAX_GROUPS * MAX_IDS_PER_GROUP;
    localparam int WORDS = (NBITS + 31) / 32;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W = WA_W + 5;
    localparam int CW    = GRP_W + NG_W + 1;
    localparam int XW    = (BIT_W > CNT_W) ? BIT_W : CNT_W;

    logic [CNT_W-1:0] ipg_reg;
    logic [NG_W-1:0]  ngr_reg;
    logic [ID_W-1:0]  tot_reg;
    logic [ID_W-1:0]  id_reg;
    logic             dir_reg;

    logic [GRP_W-1:0] cur_g_reg, cur_g_next;
    logic [NG_W-1:0]  left_reg, left_next;
    logic [GRP_W-1:0] last_g_reg, last_g_next;
    logic [ID_W-1:0]  global_reg, global_next;

    logic [CNT_W-1:0] free_cnt_reg [MAX_GROUPS];
    logic [CNT_W-1:0] dir_cnt_reg  [MAX_GROUPS];
    logic [CNT_W-1:0] tail_reg     [MAX_GROUPS];

    logic [WA_W-1:0]  addr_reg, first_addr_reg, last_addr_reg;
    logic [4:0]       lo_reg, hi_reg, found_reg;
    logic [CNT_W-1:0] n_reg;
    logic [BIT_W-1:0] gbase_reg;
    logic [31:0]      wbuf_reg;

    logic [31:0]      mem [WORDS];
    logic [WORDS-1:0] vld_reg;
    logic [31:0]      rdata_reg;
    logic             rvld_reg;

    logic [1:0]       res_status_reg;
    logic [ID_W-1:0]  res_id_reg;
    gba_out_t         out_reg;

    logic [CNT_W-1:0] ipg_eff;
    logic [NG_W-1:0]  ng_eff;
    logic [CNT_W-1:0] n_cur;
    logic [BIT_W-1:0] gbase_cur;
    logic [BIT_W-1:0] lastbit_cur;
    logic [31:0]      word_now;
    logic [4:0]       lo_now, hi_now, hit_pos;
    logic [31:0]      free_mask;
    logic [ID_W-1:0]  div_q;
    logic [CNT_W-1:0] div_r;
    logic [GRP_W-1:0] q_g;
    logic [BIT_W-1:0] free_bit;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] tail_cap;
    logic [CNT_W-1:0] fmt_n;
    logic [ID_W:0]    fmt_sum;
    logic             mem_we;
    logic [31:0]      mem_wdata;
    logic             div_busy;

    function automatic logic [CNT_W-1:0] ids_in_group(
        input logic [GRP_W-1:0] g,
        input logic [CNT_W-1:0] ipg,
        input logic [NG_W-1:0]  ng,
        input logic [ID_W-1:0]  tot
    );
        logic [ID_W:0] lead;
        logic [ID_W:0] rem;
        lead = (ID_W + 1)'(ng - NG_W'(1)) * (ID_W + 1)'(ipg);
        rem  = {1'b0, tot} - lead;
        if (CW'(g) + CW'(1) < CW'(ng))
        begin
            return ipg;
        end
        if ({1'b0, tot} <= lead)
        begin
            return '0;
        end
        return (rem > (ID_W + 1)'(ipg)) ? ipg : rem[CNT_W-1:0];
    endfunction

    assign ipg_eff = (ipg_reg == '0) ? CNT_W'(1) :
                     ((ID_W + 1)'(ipg_reg) > (ID_W + 1)'(MAX_IDS_PER_GROUP)) ?
                     CNT_W'(MAX_IDS_PER_GROUP) : ipg_reg;
    assign ng_eff  = (ngr_reg == '0) ? NG_W'(1) :
                     (CW'(ngr_reg) > CW'(MAX_GROUPS)) ? NG_W'(MAX_GROUPS) : ngr_reg;

    assign n_cur       = ids_in_group(cur_g_reg, ipg_eff, ng_eff, tot_reg);
    assign gbase_cur   = BIT_W'(cur_g_reg) * BIT_W'(MAX_IDS_PER_GROUP);
    assign lastbit_cur = gbase_cur + BIT_W'(n_cur) - BIT_W'(1);

    // bitmap word search
    assign word_now = rvld_reg ? rdata_reg : '0;
    assign lo_now   = (addr_reg == first_addr_reg) ? lo_reg : 5'd0;
    assign hi_now   = (addr_reg == last_addr_reg) ? hi_reg : 5'd31;

    always_comb
    begin
        hit_pos = '0;
        for (int k = 0; k < 32; k++)
        begin
            free_mask[k] = !word_now[k] && (5'(k) >= lo_now) && (5'(k) <= hi_now);
        end
        for (int k = 31; k >= 0; k--)
        begin
            if (free_mask[k])
            begin
                hit_pos = 5'(k);
            end
        end
    end

    // free path
    assign q_g      = GRP_W'(div_q);
    assign free_bit = BIT_W'(q_g) * BIT_W'(MAX_IDS_PER_GROUP) + BIT_W'(div_r);

    assign slot     = CNT_W'(XW'({addr_reg, found_reg}) - XW'(gbase_reg));
    assign tail_cap = (tail_reg[cur_g_reg] > n_reg) ? n_reg : tail_reg[cur_g_reg];

    assign fmt_n   = (CW'(cur_g_reg) < CW'(ng_eff)) ?
                     ids_in_group(cur_g_reg, ipg_eff, ng_eff, tot_reg) : '0;
    assign fmt_sum = {1'b0, global_reg} + (ID_W + 1)'(fmt_n);

    gba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (id_reg - ID_W'(1)),
        .divisor   (ipg_eff),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        sts.grp_exhausted = left_reg == '0;
        sts.grp_skip      = (free_cnt_reg[cur_g_reg] == '0) || (n_cur == '0);
        sts.word_hit      = |free_mask;
        sts.word_last     = addr_reg == last_addr_reg;
        sts.div_busy      = div_busy;
        sts.id_zero       = id_reg == '0;
        sts.free_bad      = ((ID_W + 1)'(div_q) >= (ID_W + 1)'(ng_eff)) ||
                            (div_r >= ids_in_group(q_g, ipg_eff, ng_eff, tot_reg));
        sts.fmt_last      = cur_g_reg == GRP_W'(MAX_GROUPS - 1);
    end

    always_comb
    begin
        cur_g_next  = cur_g_reg;
        left_next   = left_reg;
        last_g_next = last_g_reg;
        global_next = global_reg;
        if (cmd.alloc_init)
        begin
            cur_g_next = (CW'(last_g_reg) < CW'(ng_eff)) ? last_g_reg : '0;
            left_next  = ng_eff;
        end
        else if (cmd.grp_next)
        begin
            cur_g_next = (CW'(cur_g_reg) + CW'(1) >= CW'(ng_eff)) ? '0 :
                         cur_g_reg + GRP_W'(1);
            left_next  = left_reg - NG_W'(1);
        end
        else if (cmd.free_locate)
        begin
            cur_g_next = q_g;
        end
        else if (cmd.fmt_init)
        begin
            cur_g_next  = '0;
            last_g_next = '0;
            global_next = '0;
        end
        else if (cmd.fmt_step)
        begin
            cur_g_next  = cur_g_reg + GRP_W'(1);
            global_next = (fmt_sum > (ID_W + 1)'(FREE_MAX)) ? FREE_MAX : fmt_sum[ID_W-1:0];
        end
        else if (cmd.alloc_commit)
        begin
            last_g_next = cur_g_reg;
            global_next = (global_reg != '0) ? global_reg - ID_W'(1) : global_reg;
        end
        else if (cmd.free_commit)
        begin
            global_next = (global_reg < FREE_MAX) ? global_reg + ID_W'(1) : global_reg;
        end
    end

    always_comb
    begin
        mem_we    = cmd.alloc_commit || cmd.free_commit;
        mem_wdata = cmd.alloc_commit ? (wbuf_reg | (32'd1 << found_reg)) :
                                       (word_now & ~(32'd1 << found_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipg_reg        <= IPG_RST;
            ngr_reg        <= NG_RST;
            tot_reg        <= TOTAL_RST;
            cur_g_reg      <= '0;
            left_reg       <= '0;
            last_g_reg     <= '0;
            global_reg     <= '0;
            vld_reg        <= '0;
            res_status_reg <= ST_OK;
            for (int g = 0; g < MAX_GROUPS; g++)
            begin
                free_cnt_reg[g] <= '0;
                dir_cnt_reg[g]  <= '0;
                tail_reg[g]     <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_IPG:   ipg_reg <= cfg_data[CNT_W-1:0];
                    CFG_NG:    ngr_reg <= cfg_data[NG_W-1:0];
                    CFG_TOTAL: tot_reg <= cfg_data;
                    default:   ;
                endcase
            end
            cur_g_reg  <= cur_g_next;
            left_reg   <= left_next;
            last_g_reg <= last_g_next;
            global_reg <= global_next;

            if (cmd.take_in)
            begin
                res_status_reg <= ST_OK;
            end
            else if (cmd.res_nofree)
            begin
                res_status_reg <= ST_NOFREE;
            end
            else if (cmd.res_range)
            begin
                res_status_reg <= ST_RANGE;
            end

            if (cmd.fmt_init)
            begin
                vld_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end

            if (cmd.fmt_step)
            begin
                free_cnt_reg[cur_g_reg] <= fmt_n;
                dir_cnt_reg[cur_g_reg]  <= '0;
                tail_reg[cur_g_reg]     <= fmt_n;
            end
            else if (cmd.alloc_commit)
            begin
                free_cnt_reg[cur_g_reg] <= free_cnt_reg[cur_g_reg] - CNT_W'(1);
                if (dir_reg && dir_cnt_reg[cur_g_reg] < CNT_MAX)
                begin
                    dir_cnt_reg[cur_g_reg] <= dir_cnt_reg[cur_g_reg] + CNT_W'(1);
                end
                if (slot >= n_reg - tail_cap)
                begin
                    tail_reg[cur_g_reg] <= n_reg - (slot + CNT_W'(1));
                end
            end
            else if (cmd.free_commit)
            begin
                if (dir_reg && dir_cnt_reg[cur_g_reg] != '0)
                begin
                    dir_cnt_reg[cur_g_reg] <= dir_cnt_reg[cur_g_reg] - CNT_W'(1);
                end
                if (free_cnt_reg[cur_g_reg] < CNT_MAX)
                begin
                    free_cnt_reg[cur_g_reg] <= free_cnt_reg[cur_g_reg] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            id_reg     <= in_data.id_in;
            dir_reg    <= in_data.is_directory;
            res_id_reg <= '0;
        end
        if (cmd.grp_open)
        begin
            addr_reg       <= gbase_cur[BIT_W-1:5];
            first_addr_reg <= gbase_cur[BIT_W-1:5];
            last_addr_reg  <= lastbit_cur[BIT_W-1:5];
            lo_reg         <= gbase_cur[4:0];
            hi_reg         <= lastbit_cur[4:0];
            n_reg          <= n_cur;
            gbase_reg      <= gbase_cur;
        end
        else if (cmd.word_next)
        begin
            addr_reg <= addr_reg + WA_W'(1);
        end
        else if (cmd.free_locate)
        begin
            addr_reg  <= free_bit[BIT_W-1:5];
            found_reg <= free_bit[4:0];
        end
        if (cmd.word_check)
        begin
            wbuf_reg  <= word_now;
            found_reg <= hit_pos;
        end
        if (cmd.alloc_commit)
        begin
            res_id_reg <= ID_W'(ID_W'(cur_g_reg) * ID_W'(ipg_eff)) + ID_W'(slot) + ID_W'(1);
        end
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg];
        rvld_reg  <= vld_reg[addr_reg];
        if (cmd.load_out)
        begin
            out_reg.status     <= res_status_reg;
            out_reg.id_out     <= res_id_reg;
            out_reg.free_total <= global_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== bench/grouped_bitmap_id_allocator_top_test.sv =====
// testbench for the grouped bitmap id allocator: directed table, random traffic, config sweep
`timescale 1ns / 1ps
module grouped_bitmap_id_allocator_top_test;
    import gba_pkg::*;

    localparam int NGRP = 16;
    localparam int NIPG = 256;
    localparam int NBITS = NGRP * NIPG;
    localparam int LIMIT = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    gba_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    gba_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ID_W-1:0] cfg_data = '0;

    always #5 clk = ~clk;

    grouped_bitmap_id_allocator_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // allocator shadow state
    logic [8:0] reg_ipg;
    logic [4:0] reg_ng;
    logic [12:0] reg_total;
    bit used_map [NBITS];
    int grp_free [NGRP];
    int grp_dir [NGRP];
    int grp_tail [NGRP];
    int pool_free;
    int last_grp;

    gba_out_t pending_results [$];
    int live_ids [$];
    int errors = 0;
    int cycles = 0;

    function automatic int ipg_eff();
        return reg_ipg < 1 ? 1 : (reg_ipg > NIPG ? NIPG : int'(reg_ipg));
    endfunction

    function automatic int ng_eff();
        return reg_ng < 1 ? 1 : (reg_ng > NGRP ? NGRP : int'(reg_ng));
    endfunction

    function automatic int group_size(int g);
        int ipg;
        int ng;
        int lead;
        int rem;
        ipg = ipg_eff();
        ng = ng_eff();
        if (g + 1 < ng)
            return ipg;
        lead = (ng - 1) * ipg;
        if (reg_total <= lead)
            return 0;
        rem = reg_total - lead;
        return rem > ipg ? ipg : rem;
    endfunction

    function automatic void format_shadow();
        int sum;
        int n;
        sum = 0;
        foreach (used_map[b])
            used_map[b] = 0;
        for (int g = 0; g < NGRP; g++)
        begin
            n = g < ng_eff() ? group_size(g) : 0;
            grp_free[g] = n;
            grp_dir[g] = 0;
            grp_tail[g] = n;
            sum += n;
        end
        pool_free = sum > 8191 ? 8191 : sum;
        last_grp = 0;
    endfunction

    function automatic bit claim_in_group(int g, bit dir, output int id);
        int n;
        int i;
        int tl;
        id = 0;
        if (grp_free[g] == 0)
            return 0;
        n = group_size(g);
        for (i = 0; i < n; i++)
            if (!used_map[g * NIPG + i])
                break;
        if (i >= n)
            return 0;
        used_map[g * NIPG + i] = 1;
        grp_free[g]--;
        if (dir && grp_dir[g] < 511)
            grp_dir[g]++;
        tl = grp_tail[g] > n ? n : grp_tail[g];
        if (i >= n - tl)
            grp_tail[g] = n - (i + 1);
        if (pool_free > 0)
            pool_free--;
        id = g * ipg_eff() + i + 1;
        last_grp = g;
        return 1;
    endfunction

    function automatic gba_out_t allocator_result(gba_in_t w);
        gba_out_t r;
        int ng;
        int first;
        int id;
        int g;
        int i;
        bit ok;
        r = '0;
        ng = ng_eff();
        if (w.action == ACT_ALLOC)
        begin
            first = last_grp < ng ? last_grp : 0;
            ok = 0;
            for (g = first; g < ng && !ok; g++)
                ok = claim_in_group(g, w.is_directory, id);
            for (g = 0; g < first && !ok; g++)
                ok = claim_in_group(g, w.is_directory, id);
            if (ok)
            begin
                r.id_out = id[ID_W-1:0];
                live_ids.push_back(id);
            end
            else
                r.status = ST_NOFREE;
        end
        else if (w.action == ACT_FREE)
        begin
            ok = w.id_in != 0;
            if (ok)
            begin
                g = (w.id_in - 1) / ipg_eff();
                i = (w.id_in - 1) % ipg_eff();
                ok = g < ng && i < group_size(g);
            end
            if (!ok)
                r.status = ST_RANGE;
            else
            begin
                used_map[g * NIPG + i] = 0;
                if (w.is_directory && grp_dir[g] > 0)
                    grp_dir[g]--;
                if (grp_free[g] < 511)
                    grp_free[g]++;
                if (pool_free < 8191)
                    pool_free++;
            end
        end
        else if (w.action == ACT_FORMAT)
        begin
            format_shadow();
            live_ids.delete();
        end
        r.free_total = pool_free[ID_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // result checker with stall pattern
    always @(posedge clk)
    begin
        gba_out_t e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                e = pending_results.pop_front();
                if (out_data.status !== e.status)
                    report_mismatch("status", out_data.status, e.status);
                if (out_data.id_out !== e.id_out)
                    report_mismatch("id_out", out_data.id_out, e.id_out);
                if (out_data.free_total !== e.free_total)
                    report_mismatch("free_total", out_data.free_total, e.free_total);
            end
        end
        if (cycles % 3000 < 800)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (cycles >= LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_word(gba_in_t w, bit has_want, gba_out_t want);
        gba_out_t p;
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = allocator_result(w);
        if (has_want && p !== want)
            report_mismatch("table row", p, want);
        pending_results.push_back(p);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[ID_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_IPG)
            reg_ipg = val[8:0];
        else if (idx == CFG_NG)
            reg_ng = val[4:0];
        else if (idx == CFG_TOTAL)
            reg_total = val[12:0];
        @(posedge clk);
    endtask

    function automatic gba_in_t mk(logic [1:0] a, int id, bit dir);
        gba_in_t w;
        w.action = a;
        w.id_in = id[ID_W-1:0];
        w.is_directory = dir;
        return w;
    endfunction

    function automatic gba_out_t res(logic [1:0] s, int id, int ft);
        gba_out_t r;
        r.status = s;
        r.id_out = id[ID_W-1:0];
        r.free_total = ft[ID_W-1:0];
        return r;
    endfunction

    typedef struct {
        gba_in_t w;
        bit has_want;
        gba_out_t want;
    } stim_row_t;

    task automatic random_phase(int count);
        gba_in_t w;
        int k;
        int id;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            w.is_directory = 1'($urandom_range(0, 1));
            w.id_in = ID_W'($urandom_range(0, 8191));
            if (k < 50)
                w.action = ACT_ALLOC;
            else if (k < 85 && live_ids.size() > 0)
            begin
                id = $urandom_range(0, live_ids.size() - 1);
                w.action = ACT_FREE;
                w.id_in = live_ids[id][ID_W-1:0];
                live_ids.delete(id);
            end
            else if (k < 95)
            begin
                w.action = ACT_FREE;
                if (k < 90)
                    w.id_in = ID_W'($urandom_range(0, 4096));
            end
            else if (k < 98)
                w.action = ACT_NOP;
            else
                w.action = ACT_FORMAT;
            send_word(w, 0, '0);
        end
    endtask

    initial
    begin
        stim_row_t rows [$];
        reg_ipg = IPG_RST;
        reg_ng = NG_RST;
        reg_total = TOTAL_RST;
        format_shadow();
        pool_free = 0;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_free[g] = 0;
            grp_tail[g] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset counts are zero so allocate fails until format
        rows.push_back('{mk(ACT_ALLOC, 0, 0), 1, res(ST_NOFREE, 0, 0)});
        rows.push_back('{mk(ACT_FREE, 0, 1), 1, res(ST_RANGE, 0, 0)});
        rows.push_back('{mk(ACT_FREE, 1, 0), 1, res(ST_OK, 0, 1)});
        rows.push_back('{mk(ACT_NOP, 8191, 1), 1, res(ST_OK, 0, 1)});
        rows.push_back('{mk(ACT_FORMAT, 0, 0), 1, res(ST_OK, 0, 4096)});
        rows.push_back('{mk(ACT_ALLOC, 0, 1), 1, res(ST_OK, 1, 4095)});
        rows.push_back('{mk(ACT_ALLOC, 0, 0), 1, res(ST_OK, 2, 4094)});
        rows.push_back('{mk(ACT_FREE, 4097, 0), 1, res(ST_RANGE, 0, 4094)});
        rows.push_back('{mk(ACT_FREE, 8191, 1), 1, res(ST_RANGE, 0, 4094)});
        rows.push_back('{mk(ACT_FREE, 4096, 1), 0, '0});
        rows.push_back('{mk(ACT_FREE, 1, 1), 0, '0});
        rows.push_back('{mk(ACT_FREE, 1, 1), 0, '0});
        rows.push_back('{mk(ACT_ALLOC, 0, 1), 0, '0});
        rows.push_back('{mk(ACT_FREE, 2, 0), 0, '0});
        rows.push_back('{mk(ACT_ALLOC, 0, 0), 0, '0});
        foreach (rows[r])
            send_word(rows[r].w, rows[r].has_want, rows[r].want);
        random_phase(250);
        wait_drained();

        // small store to reach exhaustion, full groups and wraps
        write_reg(CFG_IPG, 5);
        write_reg(CFG_NG, 3);
        write_reg(CFG_TOTAL, 13);
        send_word(mk(ACT_FORMAT, 0, 0), 1, res(ST_OK, 0, 13));
        for (int n = 0; n < 14; n++)
            send_word(mk(ACT_ALLOC, 0, n[0]), 0, '0);
        send_word(mk(ACT_FREE, 14, 0), 1, res(ST_RANGE, 0, 0));
        random_phase(400);
        wait_drained();

        // extremes, including clamped zero settings and a stale last group
        write_reg(CFG_IPG, 0);
        write_reg(CFG_NG, 0);
        write_reg(CFG_TOTAL, 0);
        random_phase(60);
        send_word(mk(ACT_FORMAT, 0, 0), 1, res(ST_OK, 0, 0));
        random_phase(60);
        wait_drained();
        write_reg(CFG_IPG, 511);
        write_reg(CFG_NG, 31);
        write_reg(CFG_TOTAL, 8191);
        send_word(mk(ACT_FORMAT, 0, 0), 1, res(ST_OK, 0, 4096));
        random_phase(300);
        wait_drained();
        write_reg(CFG_IPG, 8);
        write_reg(CFG_NG, 16);
        write_reg(CFG_TOTAL, 100);
        random_phase(30);
        send_word(mk(ACT_FORMAT, 0, 0), 0, '0);
        random_phase(400);
        wait_drained();
        write_reg(CFG_IPG, 1);
        write_reg(CFG_NG, 1);
        write_reg(CFG_TOTAL, 1);
        send_word(mk(ACT_FORMAT, 0, 0), 1, res(ST_OK, 0, 1));
        random_phase(150);
        wait_drained();
        write_reg(CFG_IPG, 256);
        write_reg(CFG_NG, 4);
        write_reg(CFG_TOTAL, 4096);
        send_word(mk(ACT_FORMAT, 0, 0), 1, res(ST_OK, 0, 1024));
        random_phase(280);
        wait_drained();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== grouped_bitmap_id_allocator_top.f =====
rtl/gba_pkg.sv
rtl/gba_div.sv
rtl/gba_ctrl.sv
rtl/gba_dp.sv
rtl/grouped_bitmap_id_allocator_top.sv
bench/grouped_bitmap_id_allocator_top_test.sv
